>>> rtl/gblur_pkg.sv
// Shared types and constants for the 3x3 RGB Gaussian blur.
// Used by the control, datapath, queue and top modules of the block and by its testbench.
package gblur_pkg;

    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd768;

    // register index as decoded from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int OUTQ_DEPTH = 3;
    localparam int QCNT_W     = 2;

    typedef logic [PIX_W-1:0] pixel_t;  // red [7:0], green [15:8], blue [23:16]

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    // control for the item in the read/compute stage
    typedef struct packed {
        logic   valid;
        logic   emit;        // item produces a result
        logic   right_edge;  // right column replicates the center column
        logic   left_center; // left column replicates the center column
        logic   last;        // result closes the frame
        logic   proc;        // item builds a new window column
        logic   use_mem;     // line stores hold rows above
        logic   top_is_mid;  // second row: top replicates middle
        logic   bot_pix;     // bottom row is the incoming pixel
        logic   wr;          // write the line stores back
        logic   fwd;         // previous item wrote the same entry
        pixel_t pix;
    } stage_t;

    typedef struct packed {
        pixel_t pix;
        logic   last;
    } out_item_t;

endpackage

>>> rtl/gblur_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old data.
module gblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/gblur_ctrl.sv
// Input stage: position counters, result sequencing and line store read issue.
// Depends on gblur_pkg.
module gblur_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 restart,
    input  logic [gblur_pkg::WIDTH_BITS-1:0]     image_width,
    input  logic [gblur_pkg::HEIGHT_BITS-1:0]    image_height,
    input  logic                                 in_valid,
    input  gblur_pkg::opcode_t                   in_opcode,
    input  gblur_pkg::pixel_t                    in_pixel,
    output logic                                 in_ready,
    input  logic [gblur_pkg::QCNT_W-1:0]         q_count,
    output logic                                 rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output gblur_pkg::stage_t                    s1,
    output logic [$clog2(MAX_WIDTH)-1:0]         s1_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CX_W  = COL_W + 1;
    localparam int WC_W  = (CX_W > gblur_pkg::WIDTH_BITS) ? CX_W : gblur_pkg::WIDTH_BITS;
    localparam int ROW_W = gblur_pkg::HEIGHT_BITS + 1;

    logic [ROW_W-1:0]                  in_row_reg, in_row_next;
    logic [COL_W-1:0]                  in_col_reg, in_col_next;
    logic [gblur_pkg::HEIGHT_BITS-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0]                  out_col_reg, out_col_next;
    gblur_pkg::stage_t                 s1_reg, s1_next;
    logic [COL_W-1:0]                  s1_addr_reg, s1_addr_next;

    logic [WC_W-1:0]                   width_ext;
    logic [CX_W-1:0]                   w_eff, w_m1;
    logic [gblur_pkg::HEIGHT_BITS-1:0] h_eff;
    logic [ROW_W-1:0]                  h_ext;
    logic [COL_W-1:0]                  ic;
    logic [CX_W-1:0]                   ic_inc, out_col_inc;
    logic [ROW_W-1:0]                  out_row_inc;
    logic accept, ignore, col_first, row_ge1, row_ge2, row_le_h, row_lt_h, row_eq1;
    logic edge_emit, finish, proc, emit, out_last, out_wrap, col_wrap;

    // effective frame size: zero counts as one, width capped at the line store depth
    always_comb
    begin
        width_ext = WC_W'(image_width);
        if (image_width == '0)
        begin
            w_eff = CX_W'(1);
        end
        else if (width_ext > WC_W'(MAX_WIDTH))
        begin
            w_eff = CX_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CX_W'(image_width);
        end
        h_eff = (image_height == '0) ? gblur_pkg::HEIGHT_BITS'(1) : image_height;
    end

    assign h_ext  = {1'b0, h_eff};
    assign w_m1   = w_eff - CX_W'(1);
    assign ic     = ({1'b0, in_col_reg} >= w_eff) ? w_m1[COL_W-1:0] : in_col_reg;
    assign ic_inc = {1'b0, ic} + CX_W'(1);

    assign accept    = in_valid && in_ready;
    assign ignore    = (in_opcode == gblur_pkg::OP_DRAIN) != (in_row_reg >= h_ext);
    assign col_first = (ic == '0);
    assign row_ge1   = (in_row_reg != '0);
    assign row_ge2   = (in_row_reg >= ROW_W'(2));
    assign row_le_h  = (in_row_reg <= h_ext);
    assign row_lt_h  = (in_row_reg < h_ext);
    assign row_eq1   = (in_row_reg == ROW_W'(1));
    assign col_wrap  = (ic_inc >= w_eff);

    assign out_col_inc = {1'b0, out_col_reg} + CX_W'(1);
    assign out_row_inc = {1'b0, out_row_reg} + ROW_W'(1);
    assign out_wrap    = (out_col_inc >= w_eff);
    assign out_last    = (out_row_inc >= h_ext) && out_wrap;

    // row start: right edge result of the row before last
    assign edge_emit = !ignore && col_first && row_ge2;
    assign finish    = edge_emit && out_last;
    assign proc      = !ignore && !finish && row_le_h;
    assign emit      = edge_emit || (proc && !col_first && row_ge1);

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                if (out_last)
                begin
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[gblur_pkg::HEIGHT_BITS-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
            if (!ignore)
            begin
                if (finish)
                begin
                    in_row_next = '0;
                    in_col_next = '0;
                end
                else if (col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = ic_inc[COL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        s1_next             = '0;
        s1_next.valid       = accept;
        s1_next.emit        = emit;
        s1_next.right_edge  = edge_emit;
        s1_next.left_center = (out_col_reg == '0);
        s1_next.last        = out_last;
        s1_next.proc        = proc;
        s1_next.use_mem     = row_ge1;
        s1_next.top_is_mid  = row_eq1;
        s1_next.bot_pix     = row_lt_h;
        s1_next.wr          = proc && row_lt_h;
        // the item now in the compute stage writes this entry in this cycle
        s1_next.fwd         = s1_reg.valid && s1_reg.wr && (s1_addr_reg == ic);
        s1_next.pix         = in_pixel;
        s1_addr_next        = accept ? ic : s1_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            s1_reg      <= '0;
            s1_addr_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            s1_reg      <= s1_next;
            s1_addr_reg <= s1_addr_next;
        end
    end

    // room for the item in flight plus one more
    assign in_ready = ({1'b0, q_count} + {2'b0, s1_reg.valid}) < 3'(gblur_pkg::OUTQ_DEPTH);
    assign rd_en    = accept && proc;
    assign rd_addr  = ic;
    assign s1       = s1_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

>>> rtl/gblur_datapath.sv
// Compute stage: column build from line store data, window, 3x3 weighted sum,
// line store write-back with forwarding. Depends on gblur_pkg.
module gblur_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gblur_pkg::stage_t             s1,
    input  logic [$clog2(MAX_WIDTH)-1:0]  s1_addr,
    input  gblur_pkg::pixel_t             up_rd,
    input  gblur_pkg::pixel_t             mid_rd,
    output logic                          wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    output gblur_pkg::pixel_t             up_wr,
    output gblur_pkg::pixel_t             mid_wr,
    output logic                          push,
    output gblur_pkg::out_item_t          push_item
);

    localparam int CW = gblur_pkg::CHAN_W;

    // window: entries 0..2 newest column, 3..5 the one before; top, middle, bottom
    gblur_pkg::pixel_t win_reg [6];
    gblur_pkg::pixel_t fwd_up_reg, fwd_mid_reg;

    gblur_pkg::pixel_t mid_mem, up_mem;
    gblur_pkg::pixel_t col [3];
    gblur_pkg::pixel_t lft [3];
    gblur_pkg::pixel_t rgt [3];

    function automatic logic [CW-1:0] blur_chan(
        input logic [CW-1:0] l0, input logic [CW-1:0] l1, input logic [CW-1:0] l2,
        input logic [CW-1:0] c0, input logic [CW-1:0] c1, input logic [CW-1:0] c2,
        input logic [CW-1:0] r0, input logic [CW-1:0] r1, input logic [CW-1:0] r2
    );
        logic [CW+1:0] sl, sc, sr;
        logic [CW+3:0] s;
        logic [CW+3:0] t;
        sl = {2'b0, l0} + {1'b0, l1, 1'b0} + {2'b0, l2};
        sc = {2'b0, c0} + {1'b0, c1, 1'b0} + {2'b0, c2};
        sr = {2'b0, r0} + {1'b0, r1, 1'b0} + {2'b0, r2};
        s  = {2'b0, sl} + {1'b0, sc, 1'b0} + {2'b0, sr};
        t  = s + (CW+4)'(8);
        // sum is at most 16*255, so the rounded quotient never exceeds 255
        return t[CW+3:4];
    endfunction

    assign mid_mem = s1.fwd ? fwd_mid_reg : mid_rd;
    assign up_mem  = s1.fwd ? fwd_up_reg  : up_rd;

    always_comb
    begin
        col[1] = s1.use_mem ? mid_mem : '0;
        col[0] = s1.use_mem ? (s1.top_is_mid ? mid_mem : up_mem) : '0;
        col[2] = s1.bot_pix ? s1.pix : col[1];
        for (int k = 0; k < 3; k++)
        begin
            lft[k] = s1.left_center ? win_reg[k] : win_reg[k+3];
            rgt[k] = s1.right_edge ? win_reg[k] : col[k];
        end
    end

    always_comb
    begin
        push_item.last = s1.last;
        for (int ch = 0; ch < 3; ch++)
        begin
            push_item.pix[ch*CW +: CW] = blur_chan(
                lft[0][ch*CW +: CW], lft[1][ch*CW +: CW], lft[2][ch*CW +: CW],
                win_reg[0][ch*CW +: CW], win_reg[1][ch*CW +: CW], win_reg[2][ch*CW +: CW],
                rgt[0][ch*CW +: CW], rgt[1][ch*CW +: CW], rgt[2][ch*CW +: CW]);
        end
    end

    assign push    = s1.valid && s1.emit;
    assign wr_en   = s1.valid && s1.wr;
    assign wr_addr = s1_addr;
    assign up_wr   = mid_mem;
    assign mid_wr  = s1.pix;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_up_reg  <= mid_mem;
            fwd_mid_reg <= s1.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1.valid && s1.proc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k+3] <= win_reg[k];
                win_reg[k]   <= col[k];
            end
        end
    end

endmodule

>>> rtl/gblur_outq.sv
// Three-entry output queue that decouples the result stream from the input side.
// Depends on gblur_pkg.
module gblur_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  gblur_pkg::out_item_t         push_item,
    output logic [gblur_pkg::QCNT_W-1:0] count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output gblur_pkg::out_item_t         m_item
);

    localparam int DEPTH = gblur_pkg::OUTQ_DEPTH;
    localparam int CW    = gblur_pkg::QCNT_W;

    gblur_pkg::out_item_t q_reg [DEPTH];
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic pop;

    assign pop = m_valid && m_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == CW'(DEPTH - 1)) ? '0 : head_reg + CW'(1);
        end
        if (push)
        begin
            tail_next = (tail_reg == CW'(DEPTH - 1)) ? '0 : tail_reg + CW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign count   = count_reg;
    assign m_valid = (count_reg != '0);
    assign m_item  = q_reg[head_reg];

endmodule

>>> rtl/gaussian_blur_3x3_rgb.sv
// 3x3 Gaussian blur (1-2-1 kernel) on a raster-order RGB stream, clamp-to-edge.
// Throughput: one transaction per cycle while the queue has room, set by one read
// and one write-back of the two line stores per pixel. A result is offered after
// the input that completes its window (one row plus one pixel behind it).
// Reset (rst_n, async, active low) clears counters, window and output queue and
// loads width 1024 / height 768; line stores are not cleared.
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]  s_axis_tuser,   // opcode
    // filtered output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast    // frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [gblur_pkg::WIDTH_BITS-1:0]  image_width_reg;
    logic [gblur_pkg::HEIGHT_BITS-1:0] image_height_reg;
    logic cfg_wr;

    logic                         rd_en, wr_en;
    logic [COL_W-1:0]             rd_addr, wr_addr, s1_addr;
    gblur_pkg::pixel_t            up_rd, mid_rd, up_wr, mid_wr;
    gblur_pkg::stage_t            s1;
    logic                         push;
    gblur_pkg::out_item_t         push_item, m_item;
    logic [gblur_pkg::QCNT_W-1:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= gblur_pkg::WIDTH_RESET;
            image_height_reg <= gblur_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                gblur_pkg::REG_WIDTH:  image_width_reg  <= pwdata[gblur_pkg::WIDTH_BITS-1:0];
                gblur_pkg::REG_HEIGHT: image_height_reg <= pwdata[gblur_pkg::HEIGHT_BITS-1:0];
                default:               image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gblur_pkg::REG_WIDTH:
                prdata = {{(32 - gblur_pkg::WIDTH_BITS){1'b0}}, image_width_reg};
            gblur_pkg::REG_HEIGHT:
                prdata = {{(32 - gblur_pkg::HEIGHT_BITS){1'b0}}, image_height_reg};
            default:
                prdata = '0;
        endcase
    end

    gblur_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_wr),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (s_axis_tvalid),
        .in_opcode    (gblur_pkg::opcode_t'(s_axis_tuser[0])),
        .in_pixel     (s_axis_tdata),
        .in_ready     (s_axis_tready),
        .q_count      (q_count),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1           (s1),
        .s1_addr      (s1_addr)
    );

    gblur_ram #(
        .WIDTH (gblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (up_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (up_rd)
    );

    gblur_ram #(
        .WIDTH (gblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (mid_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mid_rd)
    );

    gblur_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .s1_addr   (s1_addr),
        .up_rd     (up_rd),
        .mid_rd    (mid_rd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .up_wr     (up_wr),
        .mid_wr    (mid_wr),
        .push      (push),
        .push_item (push_item)
    );

    gblur_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .count     (q_count),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_item    (m_item)
    );

    assign m_axis_tdata = m_item.pix;
    assign m_axis_tlast = m_item.last;

endmodule

>>> rtl/gblur_checker.sv
// Port-level checks for gaussian_blur_3x3_rgb, attached by bind.
// Depends only on the top level's ports.
module gblur_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a newly offered result follows an input transaction through the compute stage and output queue registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a causing input transaction");

    // with the output queue empty the input side is never held off
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // width register reads back what was written
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
            paddr[2] || (prdata[10:0] == $past(pwdata[10:0])))
        else $error("width register readback mismatch");

endmodule

bind gaussian_blur_3x3_rgb gblur_checker u_gblur_checker (.*);

>>> tb/gaussian_blur_3x3_rgb_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gaussian_blur_3x3_rgb: random-gap pixel/drain stream in, stalled
// result stream out, every result compared against an in-bench line-store blur predictor.
// Depends on rtl/gblur_pkg.sv and rtl/gaussian_blur_3x3_rgb.sv.
module gaussian_blur_3x3_rgb_tb;

    localparam int MAX_W        = 1024;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 700;

    localparam logic [2:0] WIDTH_ADDR  = {gblur_pkg::REG_WIDTH, 2'b00};
    localparam logic [2:0] HEIGHT_ADDR = {gblur_pkg::REG_HEIGHT, 2'b00};

    typedef logic [2:0][gblur_pkg::PIX_W-1:0] column_t;  // [0] top, [1] middle, [2] bottom

    typedef struct packed {
        logic [gblur_pkg::CHAN_W-1:0] red;
        logic [gblur_pkg::CHAN_W-1:0] green;
        logic [gblur_pkg::CHAN_W-1:0] blue;
        logic                         frame_last;
    } blur_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // red_in, green_in, blue_in
    logic [0:0]  s_axis_tuser  = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // red_out, green_out, blue_out
    logic        m_axis_tlast;         // frame_last

    // predictor state
    logic [gblur_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [gblur_pkg::HEIGHT_BITS-1:0] height_reg;
    gblur_pkg::pixel_t                 upper_row [MAX_W];
    gblur_pkg::pixel_t                 middle_row [MAX_W];
    column_t                           win_cur;
    column_t                           win_prev;
    int unsigned                       row_in;
    int unsigned                       col_in;
    int unsigned                       row_out;
    int unsigned                       col_out;
    blur_result_t                      expected_q [$];

    int          error_count = 0;
    int          items_taken = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    bit          bubbles_on  = 1'b0;

    gaussian_blur_3x3_rgb #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 100)
            $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ---------------- predictor ----------------

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function automatic void restart_counters();
        row_in  = 0;
        col_in  = 0;
        row_out = 0;
        col_out = 0;
    endfunction

    function automatic void reset_model();
        width_reg  = gblur_pkg::WIDTH_RESET;
        height_reg = gblur_pkg::HEIGHT_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        win_cur  = '0;
        win_prev = '0;
        restart_counters();
    endfunction

    function automatic gblur_pkg::pixel_t gauss_pixel(input column_t lc, input column_t cc,
                                                      input column_t rc);
        int unsigned       acc;
        int unsigned       val;
        int unsigned       row_wt;
        gblur_pkg::pixel_t px;
        px = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                row_wt = (k == 1) ? 2 : 1;
                acc += row_wt * (lc[k][ch*gblur_pkg::CHAN_W +: gblur_pkg::CHAN_W]
                                 + 2 * cc[k][ch*gblur_pkg::CHAN_W +: gblur_pkg::CHAN_W]
                                 + rc[k][ch*gblur_pkg::CHAN_W +: gblur_pkg::CHAN_W]);
            end
            val = (acc + 8) >> 4;
            if (val > 255)
                val = 255;
            px[ch*gblur_pkg::CHAN_W +: gblur_pkg::CHAN_W] = val[7:0];
        end
        return px;
    endfunction

    function automatic void push_blur_result(input column_t lc, input column_t cc,
                                             input column_t rc);
        gblur_pkg::pixel_t px;
        blur_result_t      res;
        px             = gauss_pixel(lc, cc, rc);
        res.red        = px[7:0];
        res.green      = px[15:8];
        res.blue       = px[23:16];
        res.frame_last = (row_out + 1 >= eff_height()) && (col_out + 1 >= eff_width());
        expected_q.push_back(res);
        if (res.frame_last)
            restart_counters();
        else
        begin
            col_out++;
            if (col_out >= eff_width())
            begin
                col_out = 0;
                row_out++;
            end
        end
    endfunction

    function automatic void predict_blur(input gblur_pkg::opcode_t op,
                                         input gblur_pkg::pixel_t pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       ir;
        int unsigned       ic;
        column_t           fresh;
        column_t           lcol;
        gblur_pkg::pixel_t mid;
        gblur_pkg::pixel_t top;
        w  = eff_width();
        h  = eff_height();
        ir = row_in;
        ic = col_in;
        // drains before frame end and pixels while draining are dropped
        if ((op == gblur_pkg::OP_DRAIN) != (ir >= h))
            return;
        items_taken++;
        if (ic >= w)
            ic = w - 1;
        // first column of a row closes the right edge of the row two above
        if (ic == 0 && ir >= 2)
        begin
            lcol = (col_out == 0) ? win_cur : win_prev;
            push_blur_result(lcol, win_cur, win_cur);
            if (row_in == 0 && row_out == 0 && col_out == 0)
                return;
        end
        if (ir <= h)
        begin
            mid = '0;
            top = '0;
            if (ir >= 1)
            begin
                mid = middle_row[ic];
                top = (ir == 1) ? mid : upper_row[ic];
            end
            fresh[0] = top;
            fresh[1] = mid;
            fresh[2] = (ir < h) ? pix : mid;
            if (ir < h)
            begin
                upper_row[ic]  = middle_row[ic];
                middle_row[ic] = pix;
            end
            if (ic >= 1 && ir >= 1)
            begin
                lcol = (col_out == 0) ? win_cur : win_prev;
                push_blur_result(lcol, win_cur, fresh);
            end
            win_prev = win_cur;
            win_cur  = fresh;
        end
        ic++;
        if (ic >= w)
        begin
            ic = 0;
            ir++;
        end
        col_in = ic;
        row_in = ir;
    endfunction

    // ---------------- drivers ----------------

    function automatic gblur_pkg::pixel_t rand_pixel();
        gblur_pkg::pixel_t px;
        px = gblur_pkg::pixel_t'($urandom);
        for (int ch = 0; ch < 3; ch++)
            if ($urandom_range(0, 7) == 0)
                px[ch*gblur_pkg::CHAN_W +: gblur_pkg::CHAN_W] =
                    $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    task automatic send_item(input gblur_pkg::opcode_t op, input gblur_pkg::pixel_t pix);
        int gap;
        gap = bubbles_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_blur(op, pix);
    endtask

    // holds off input until every expected result has left the block
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] stored;
        apb_access(1'b1, addr, value, rd);
        if (addr == WIDTH_ADDR)
        begin
            width_reg = value[gblur_pkg::WIDTH_BITS-1:0];
            stored    = 32'(width_reg);
        end
        else
        begin
            height_reg = value[gblur_pkg::HEIGHT_BITS-1:0];
            stored     = 32'(height_reg);
        end
        restart_counters();
        apb_access(1'b0, addr, 32'd0, rd);
        if (rd !== stored)
            report_mismatch("register readback", rd, stored);
    endtask

    task automatic send_frame_drain();
        int unsigned n;
        n = eff_width() + 1;
        for (int d = 0; d < n; d++)
            send_item(gblur_pkg::OP_DRAIN, rand_pixel());
    endtask

    // ---------------- tests ----------------

    task automatic test_register_reset();
        logic [31:0] rd;
        apb_access(1'b0, WIDTH_ADDR, 32'd0, rd);
        if (rd !== 32'(gblur_pkg::WIDTH_RESET))
            report_mismatch("width after reset", rd, 32'(gblur_pkg::WIDTH_RESET));
        apb_access(1'b0, HEIGHT_ADDR, 32'd0, rd);
        if (rd !== 32'(gblur_pkg::HEIGHT_RESET))
            report_mismatch("height after reset", rd, 32'(gblur_pkg::HEIGHT_RESET));
    endtask

    task automatic test_small_frames();
        gblur_pkg::pixel_t corner_px [9];
        corner_px = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                      24'hFFFFFF, 24'h000000, 24'hA5A5A5, 24'h5A5A5A};
        bubbles_on = 1'b0;
        write_reg(WIDTH_ADDR, 32'd3);
        write_reg(HEIGHT_ADDR, 32'd3);
        send_item(gblur_pkg::OP_DRAIN, 24'hFFFFFF);       // early drain, dropped
        foreach (corner_px[i])
            send_item(gblur_pkg::OP_PIXEL, corner_px[i]);
        send_item(gblur_pkg::OP_DRAIN, 24'h000000);
        send_item(gblur_pkg::OP_DRAIN, 24'h000000);
        send_item(gblur_pkg::OP_PIXEL, 24'hFFFFFF);       // pixel during drain, dropped
        send_item(gblur_pkg::OP_DRAIN, 24'h000000);
        send_item(gblur_pkg::OP_DRAIN, 24'h000000);
        send_item(gblur_pkg::OP_DRAIN, 24'h000000);       // frame already restarted, dropped
        wait_idle();
        // single-pixel frame: one column, one row
        write_reg(WIDTH_ADDR, 32'd1);
        write_reg(HEIGHT_ADDR, 32'd1);
        send_item(gblur_pkg::OP_PIXEL, 24'hFFFFFF);
        send_frame_drain();
        wait_idle();
        // zero sizes behave as one
        write_reg(WIDTH_ADDR, 32'd0);
        write_reg(HEIGHT_ADDR, 32'd0);
        send_item(gblur_pkg::OP_PIXEL, 24'h80FF01);
        send_frame_drain();
        wait_idle();
    endtask

    task automatic test_midframe_pause();
        bubbles_on = 1'b1;
        write_reg(WIDTH_ADDR, 32'd5);
        write_reg(HEIGHT_ADDR, 32'd4);
        for (int i = 0; i < 12; i++)
            send_item(gblur_pkg::OP_PIXEL, rand_pixel());
        wait_idle();
        for (int i = 12; i < 20; i++)
            send_item(gblur_pkg::OP_PIXEL, rand_pixel());
        send_frame_drain();
        wait_idle();
    endtask

    task automatic test_size_extremes();
        bubbles_on = 1'b1;
        // oversized width clamps to the line length; partial frame then restart
        write_reg(WIDTH_ADDR, 32'd2047);
        write_reg(HEIGHT_ADDR, 32'd2);
        for (int i = 0; i < 8; i++)
            send_item(gblur_pkg::OP_PIXEL, rand_pixel());
        wait_idle();
        write_reg(WIDTH_ADDR, 32'd1);
        write_reg(HEIGHT_ADDR, 32'd65535);
        for (int i = 0; i < 40; i++)
            send_item(gblur_pkg::OP_PIXEL, rand_pixel());
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned npix;
        int unsigned stop_at;
        int unsigned pause_at;
        int          first_item;
        bit          reconfig;
        first_item = items_taken;
        reconfig   = 1'b1;
        while (items_taken - first_item < RANDOM_ITEMS)
        begin
            bubbles_on = ($urandom_range(0, 3) != 0);
            if (reconfig)
            begin
                wait_idle();
                write_reg(WIDTH_ADDR, ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6)
                                                                  : $urandom_range(7, 48));
                write_reg(HEIGHT_ADDR, ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4)
                                                                   : $urandom_range(5, 10));
            end
            npix     = eff_width() * eff_height();
            stop_at  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, npix - 1) : npix;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : npix;
            for (int i = 0; i < stop_at; i++)
            begin
                if (i == pause_at)
                    wait_idle();
                if ($urandom_range(0, 29) == 0)
                    send_item(gblur_pkg::OP_DRAIN, rand_pixel());
                send_item(gblur_pkg::OP_PIXEL, rand_pixel());
            end
            if (stop_at == npix)
            begin
                for (int d = 0; d <= eff_width(); d++)
                begin
                    if ($urandom_range(0, 29) == 0)
                        send_item(gblur_pkg::OP_PIXEL, rand_pixel());
                    send_item(gblur_pkg::OP_DRAIN, rand_pixel());
                end
                if ($urandom_range(0, 4) == 0)
                    send_item(gblur_pkg::OP_DRAIN, rand_pixel());
                // back-to-back frames keep the line stores and window warm
                reconfig = ($urandom_range(0, 2) != 0);
            end
            else
                reconfig = 1'b1;
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge clk)
    begin : check_results
        blur_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.red)
                        report_mismatch("red_out", 32'(m_axis_tdata[7:0]), 32'(want.red));
                    if (m_axis_tdata[15:8] !== want.green)
                        report_mismatch("green_out", 32'(m_axis_tdata[15:8]),
                                        32'(want.green));
                    if (m_axis_tdata[23:16] !== want.blue)
                        report_mismatch("blue_out", 32'(m_axis_tdata[23:16]),
                                        32'(want.blue));
                    if (m_axis_tlast !== want.frame_last)
                        report_mismatch("frame_last", 32'(m_axis_tlast),
                                        32'(want.frame_last));
                end
                stall_left = bubbles_on ? $urandom_range(0, 4) : 0;
            end
            else if (stall_left > 0)
                stall_left--;
            m_axis_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("gaussian_blur_3x3_rgb_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_small_frames();
        test_midframe_pause();
        test_size_extremes();
        test_random_frames();
        wait_idle();
        if (error_count == 0)
            $display("gaussian_blur_3x3_rgb_tb: PASS");
        else
            $display("gaussian_blur_3x3_rgb_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/gblur_pkg.sv
rtl/gblur_ram.sv
rtl/gblur_ctrl.sv
rtl/gblur_datapath.sv
rtl/gblur_outq.sv
rtl/gaussian_blur_3x3_rgb.sv
rtl/gblur_checker.sv
tb/gaussian_blur_3x3_rgb_tb.sv
